### src/ezyz_pkg.sv
`default_nettype none
package ezyz_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int ENTRY_WIDTH_DEF = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int QF           = 30;
  // CORDIC datapath widths: x and y stay well inside two integer bits plus guard.
  localparam int XY_W         = 34;
  localparam int Z_W          = 34;
  // Clamped sine and cosine, Q2.30.
  localparam int CS_W         = 32;
  localparam int SUM_W        = CS_W + 1;

  localparam int LANE_STAGES  = CORDIC_STEPS + 1;
  localparam int MERGE_STAGES = 3;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;
  localparam int NUM_ENTRIES  = 9;

  localparam logic signed [XY_W-1:0] X_INIT = XY_W'(32'h26DD3B6A);
  localparam logic signed [XY_W-1:0] ONE_Q  = XY_W'(1) <<< QF;

  typedef struct packed {
    logic signed [CS_W-1:0] ca;
    logic signed [CS_W-1:0] sa;
    logic signed [CS_W-1:0] cb;
    logic signed [CS_W-1:0] sb;
    logic signed [CS_W-1:0] cg;
    logic signed [CS_W-1:0] sg;
  } trig_t;

  function automatic logic signed [Z_W-1:0] atan_step(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = Z_W'(536870912);
      1:  v = Z_W'(316933406);
      2:  v = Z_W'(167458907);
      3:  v = Z_W'(85004756);
      4:  v = Z_W'(42667331);
      5:  v = Z_W'(21354465);
      6:  v = Z_W'(10679838);
      7:  v = Z_W'(5340245);
      8:  v = Z_W'(2670163);
      9:  v = Z_W'(1335087);
      10: v = Z_W'(667544);
      11: v = Z_W'(333772);
      12: v = Z_W'(166886);
      13: v = Z_W'(83443);
      14: v = Z_W'(41722);
      15: v = Z_W'(20861);
      16: v = Z_W'(10430);
      17: v = Z_W'(5215);
      18: v = Z_W'(2608);
      19: v = Z_W'(1304);
      20: v = Z_W'(652);
      21: v = Z_W'(326);
      22: v = Z_W'(163);
      23: v = Z_W'(81);
      24: v = Z_W'(41);
      25: v = Z_W'(20);
      26: v = Z_W'(10);
      27: v = Z_W'(5);
      28: v = Z_W'(3);
      29: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Product of two Q2.30 values, rounded half up to Q2.30.
  function automatic logic signed [CS_W-1:0] qmul(input logic signed [CS_W-1:0] a,
                                                  input logic signed [CS_W-1:0] b);
    logic signed [2*CS_W-1:0] p;
    p = (2*CS_W)'(a) * (2*CS_W)'(b);
    p = p + ((2*CS_W)'(1) <<< (QF - 1));
    p = p >>> QF;
    return p[CS_W-1:0];
  endfunction

endpackage
`default_nettype wire

### src/ezyz_cordic_lane.sv
`default_nettype none
module ezyz_cordic_lane #(
  parameter int ANGLE_WIDTH = ezyz_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic [ezyz_pkg::LANE_STAGES-1:0]    en,
  input  wire logic signed [ANGLE_WIDTH-1:0]       angle,
  output logic signed [ezyz_pkg::CS_W-1:0]         cos_o,
  output logic signed [ezyz_pkg::CS_W-1:0]         sin_o
);
  import ezyz_pkg::*;

  logic [31:0] phase_raw;
  logic [31:0] phase_sum;
  logic [31:0] phase;
  logic        flip_in;
  logic signed [Z_W-1:0] z_in;

  logic signed [XY_W-1:0] x_r [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS];
  logic                   flip_r [CORDIC_STEPS];

  logic signed [XY_W-1:0] xf;
  logic signed [XY_W-1:0] yf;
  logic signed [XY_W-1:0] xc;
  logic signed [XY_W-1:0] yc;

  // Angles in the left half-turn are moved by pi and the results negated.
  always_comb begin
    phase_raw = 32'(unsigned'(angle)) << (32 - ANGLE_WIDTH);
    phase_sum = phase_raw + 32'h4000_0000;
    flip_in   = phase_sum[31];
    phase     = flip_in ? (phase_raw ^ 32'h8000_0000) : phase_raw;
    z_in      = {{(Z_W-32){phase[31]}}, phase};
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] x_p;
    logic signed [XY_W-1:0] y_p;
    logic signed [Z_W-1:0]  z_p;
    logic                   f_p;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    if (i == 0) begin : g_first
      assign x_p = X_INIT;
      assign y_p = '0;
      assign z_p = z_in;
      assign f_p = flip_in;
    end else begin : g_next
      assign x_p = x_r[i-1];
      assign y_p = y_r[i-1];
      assign z_p = z_r[i-1];
      assign f_p = flip_r[i-1];
    end

    assign dx = y_p >>> i;
    assign dy = x_p >>> i;

    always_ff @(posedge clk) begin
      if (en[i]) begin
        flip_r[i] <= f_p;
        if (!z_p[Z_W-1]) begin
          x_r[i] <= x_p - dx;
          y_r[i] <= y_p + dy;
          z_r[i] <= z_p - atan_step(i);
        end else begin
          x_r[i] <= x_p + dx;
          y_r[i] <= y_p - dy;
          z_r[i] <= z_p + atan_step(i);
        end
      end
    end
  end

  always_comb begin
    xf = flip_r[CORDIC_STEPS-1] ? -x_r[CORDIC_STEPS-1] : x_r[CORDIC_STEPS-1];
    yf = flip_r[CORDIC_STEPS-1] ? -y_r[CORDIC_STEPS-1] : y_r[CORDIC_STEPS-1];
    xc = (xf > ONE_Q) ? ONE_Q : ((xf < -ONE_Q) ? -ONE_Q : xf);
    yc = (yf > ONE_Q) ? ONE_Q : ((yf < -ONE_Q) ? -ONE_Q : yf);
  end

  always_ff @(posedge clk) begin
    if (en[LANE_STAGES-1]) begin
      cos_o <= xc[CS_W-1:0];
      sin_o <= yc[CS_W-1:0];
    end
  end

endmodule
`default_nettype wire

### src/ezyz_merge.sv
`default_nettype none
module ezyz_merge #(
  parameter int ENTRY_WIDTH = ezyz_pkg::ENTRY_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic [ezyz_pkg::MERGE_STAGES-1:0]    en,
  input  wire ezyz_pkg::trig_t                      trig,
  output logic signed [ENTRY_WIDTH-1:0]             m_o [ezyz_pkg::NUM_ENTRIES]
);
  import ezyz_pkg::*;

  localparam int SH = 32 - ENTRY_WIDTH;
  localparam logic signed [SUM_W-1:0] HALF = (SH > 0) ? (SUM_W'(1) <<< (SH - 1)) : '0;
  localparam logic signed [SUM_W-1:0] LIM  = SUM_W'(1) <<< (ENTRY_WIDTH - 2);

  // First products.
  logic signed [CS_W-1:0] bgc_r, bgs_r, sasg_r, sacg_r, casb_r, casg_r, cacg_r, sasb_r;
  logic signed [CS_W-1:0] sbcg_r, sbsg_r, ca_r, sa_r, cb_r;
  // Second products and delayed terms.
  logic signed [CS_W-1:0] cabgc_r, sabgc_r, cabgs_r, sabgs_r;
  logic signed [CS_W-1:0] sasg_q, sacg_q, casb_q, casg_q, cacg_q, sasb_q, sbcg_q, sbsg_q;
  logic signed [CS_W-1:0] cb_q;

  logic signed [SUM_W-1:0] sums [NUM_ENTRIES];

  function automatic logic signed [ENTRY_WIDTH-1:0] to_entry(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + HALF) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[ENTRY_WIDTH-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [CS_W-1:0] v);
    return {v[CS_W-1], v};
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bgc_r  <= qmul(trig.cb, trig.cg);
      bgs_r  <= qmul(trig.cb, trig.sg);
      sasg_r <= qmul(trig.sa, trig.sg);
      sacg_r <= qmul(trig.sa, trig.cg);
      casb_r <= qmul(trig.ca, trig.sb);
      casg_r <= qmul(trig.ca, trig.sg);
      cacg_r <= qmul(trig.ca, trig.cg);
      sasb_r <= qmul(trig.sa, trig.sb);
      sbcg_r <= qmul(trig.sb, trig.cg);
      sbsg_r <= qmul(trig.sb, trig.sg);
      ca_r   <= trig.ca;
      sa_r   <= trig.sa;
      cb_r   <= trig.cb;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cabgc_r <= qmul(ca_r, bgc_r);
      sabgc_r <= qmul(sa_r, bgc_r);
      cabgs_r <= qmul(ca_r, bgs_r);
      sabgs_r <= qmul(sa_r, bgs_r);
      sasg_q  <= sasg_r;
      sacg_q  <= sacg_r;
      casb_q  <= casb_r;
      casg_q  <= casg_r;
      cacg_q  <= cacg_r;
      sasb_q  <= sasb_r;
      sbcg_q  <= sbcg_r;
      sbsg_q  <= sbsg_r;
      cb_q    <= cb_r;
    end
  end

  always_comb begin
    sums[0] = ext(cabgc_r) - ext(sasg_q);
    sums[1] = -ext(cabgs_r) - ext(sacg_q);
    sums[2] = ext(casb_q);
    sums[3] = ext(sabgc_r) + ext(casg_q);
    sums[4] = -ext(sabgs_r) + ext(cacg_q);
    sums[5] = ext(sasb_q);
    sums[6] = -ext(sbcg_q);
    sums[7] = ext(sbsg_q);
    sums[8] = ext(cb_q);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        m_o[k] <= to_entry(sums[k]);
      end
    end
  end

endmodule
`default_nettype wire

### src/euler_zyz_to_rotation_matrix_core.sv
`default_nettype none
// ZYZ Euler angles to rotation matrix. Three CORDIC lanes, one per angle, turn
// alpha, beta and gamma into sine and cosine side by side; a merging stage then forms
// the nine matrix entries with two rounds of rounded products and a final round and
// saturate to +-1 in Q2.(ENTRY_WIDTH-2). The pipeline takes one item every cycle
// unless input is held off, and passes it through 31 lane stages (30 of them
// CORDIC steps) and three merge stages. A stall on the output fills empty stages
// first, so input is held off only once every stage holds an item.
module euler_zyz_to_rotation_matrix_core #(
  parameter int ANGLE_WIDTH = ezyz_pkg::ANGLE_WIDTH_DEF,
  parameter int ENTRY_WIDTH = ezyz_pkg::ENTRY_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_alpha_angle,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_beta_angle,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_gamma_angle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [ENTRY_WIDTH-1:0]      out_m00,
  output logic signed [ENTRY_WIDTH-1:0]      out_m01,
  output logic signed [ENTRY_WIDTH-1:0]      out_m02,
  output logic signed [ENTRY_WIDTH-1:0]      out_m10,
  output logic signed [ENTRY_WIDTH-1:0]      out_m11,
  output logic signed [ENTRY_WIDTH-1:0]      out_m12,
  output logic signed [ENTRY_WIDTH-1:0]      out_m20,
  output logic signed [ENTRY_WIDTH-1:0]      out_m21,
  output logic signed [ENTRY_WIDTH-1:0]      out_m22
);
  import ezyz_pkg::*;

  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] v_nxt;
  logic [PIPE_STAGES-1:0] en;
  trig_t                  trig;
  logic signed [ENTRY_WIDTH-1:0] m [NUM_ENTRIES];

  // A stage loads when it is empty or its item moves on.
  always_comb begin
    en[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    for (int k = 0; k < PIPE_STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[PIPE_STAGES-1];

  ezyz_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane_a (
    .clk(clk), .en(en[LANE_STAGES-1:0]), .angle(in_alpha_angle),
    .cos_o(trig.ca), .sin_o(trig.sa)
  );
  ezyz_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane_b (
    .clk(clk), .en(en[LANE_STAGES-1:0]), .angle(in_beta_angle),
    .cos_o(trig.cb), .sin_o(trig.sb)
  );
  ezyz_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane_g (
    .clk(clk), .en(en[LANE_STAGES-1:0]), .angle(in_gamma_angle),
    .cos_o(trig.cg), .sin_o(trig.sg)
  );

  ezyz_merge #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_merge (
    .clk(clk), .en(en[PIPE_STAGES-1:LANE_STAGES]), .trig(trig), .m_o(m)
  );

  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];

  localparam logic signed [ENTRY_WIDTH-1:0] LIM_E = ENTRY_WIDTH'(1) <<< (ENTRY_WIDTH - 2);

  // Input is held off only when the whole pipeline is full behind a stalled result.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&v_r)))
    else $error("input stalled while the pipeline has an empty stage");

  a_no_valid_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  a_m22_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_m22 <= LIM_E && out_m22 >= -LIM_E))
    else $error("m22 beyond unit range");

  a_m00_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_m00 <= LIM_E && out_m00 >= -LIM_E))
    else $error("m00 beyond unit range");

endmodule
`default_nettype wire

### verif/euler_zyz_to_rotation_matrix_core_tb.sv
`default_nettype none
module euler_zyz_to_rotation_matrix_core_tb;

  localparam int AW = 16;
  localparam int EW = 16;
  localparam int LATENCY = ezyz_pkg::PIPE_STAGES;

  typedef struct packed {
    logic signed [AW-1:0] alpha;
    logic signed [AW-1:0] beta;
    logic signed [AW-1:0] gamma;
  } angles_t;

  typedef struct packed {
    logic signed [EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [AW-1:0] in_alpha_angle = '0, in_beta_angle = '0, in_gamma_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [EW-1:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [EW-1:0] out_m20, out_m21, out_m22;

  euler_zyz_to_rotation_matrix_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_alpha_angle(in_alpha_angle), .in_beta_angle(in_beta_angle),
    .in_gamma_angle(in_gamma_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22)
  );

  angles_t pending_angles[$];
  matrix_t expected_matrices[$];
  int mismatches = 0;
  int matrices_checked = 0;
  int angles_sent = 0;
  bit hold_off = 1'b0;
  bit in_accepted = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Arithmetic shift right with floor, on 64-bit signed values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void cordic_sincos(logic [AW-1:0] raw, output longint c,
                                        output longint s);
    logic [31:0] phase;
    bit flip;
    longint x, y, z, dx, dy, one;
    longint atans[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087,
                          667544, 333772, 166886, 83443, 41722,
                          20861, 10430, 5215, 2608, 1304,
                          652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    phase = {raw, {(32-AW){1'b0}}};
    flip = 1'b0;
    x = 64'h26DD3B6A;
    y = 0;
    one = 64'd1 << 30;
    // Angles in the left half-plane are turned by pi and the result negated.
    if (32'(phase + 32'h4000_0000) >= 32'h8000_0000) begin
      phase = phase + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'(signed'(phase));
    for (int i = 0; i < 30; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atans[i];
      end else begin
        x += dx; y -= dy; z += atans[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    if (x > one) x = one;
    if (x < -one) x = -one;
    if (y > one) y = one;
    if (y < -one) y = -one;
    c = x;
    s = y;
  endfunction

  function automatic longint round_product(longint a, longint b);
    return floor_shift(a * b + (64'd1 << 29), 30);
  endfunction

  function automatic logic [EW-1:0] to_q14(longint v);
    longint lim;
    lim = 64'd1 << (EW - 2);
    v = floor_shift(v + (64'd1 << (30 - (EW - 2) - 1)), 30 - (EW - 2));
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[EW-1:0];
  endfunction

  function automatic matrix_t rotation_of(angles_t a);
    longint ca, sa, cb, sb, cg, sg, bc, bs;
    matrix_t m;
    cordic_sincos(a.alpha, ca, sa);
    cordic_sincos(a.beta, cb, sb);
    cordic_sincos(a.gamma, cg, sg);
    bc = round_product(cb, cg);
    bs = round_product(cb, sg);
    m.m00 = to_q14(round_product(ca, bc) - round_product(sa, sg));
    m.m01 = to_q14(-round_product(ca, bs) - round_product(sa, cg));
    m.m02 = to_q14(round_product(ca, sb));
    m.m10 = to_q14(round_product(sa, bc) + round_product(ca, sg));
    m.m11 = to_q14(-round_product(sa, bs) + round_product(ca, cg));
    m.m12 = to_q14(round_product(sa, sb));
    m.m20 = to_q14(-round_product(sb, cg));
    m.m21 = to_q14(round_product(sb, sg));
    m.m22 = to_q14(cb);
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch on matrix %0d: %s got %0d expected %0d",
             matrices_checked, what, got, want);
  endtask

  // Sender: bursts of items separated by random gaps. An item on offer is
  // replaced only once the last rising edge accepted it.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_accepted)) begin
      if (in_valid) begin
        angles_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_angles.size() > 0) begin
        angles_t a;
        a = pending_angles.pop_front();
        in_valid <= 1'b1;
        in_alpha_angle <= a.alpha;
        in_beta_angle <= a.beta;
        in_gamma_angle <= a.gamma;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 64;
    if (hold_off) out_stall <= 1'b1;
    else if (stall_phase < 20) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Long receiver hold-off early on, so the pipeline fills and stalls its input.
  initial begin
    repeat (110) @(posedge clk);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  // Predictor runs on accepted inputs, checker on accepted results.
  always @(posedge clk) begin
    in_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_matrices.push_back(rotation_of({in_alpha_angle, in_beta_angle,
                                               in_gamma_angle}));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matrices.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        matrix_t w;
        w = expected_matrices.pop_front();
        if (out_m00 !== w.m00) report_mismatch("m00", out_m00, w.m00);
        if (out_m01 !== w.m01) report_mismatch("m01", out_m01, w.m01);
        if (out_m02 !== w.m02) report_mismatch("m02", out_m02, w.m02);
        if (out_m10 !== w.m10) report_mismatch("m10", out_m10, w.m10);
        if (out_m11 !== w.m11) report_mismatch("m11", out_m11, w.m11);
        if (out_m12 !== w.m12) report_mismatch("m12", out_m12, w.m12);
        if (out_m20 !== w.m20) report_mismatch("m20", out_m20, w.m20);
        if (out_m21 !== w.m21) report_mismatch("m21", out_m21, w.m21);
        if (out_m22 !== w.m22) report_mismatch("m22", out_m22, w.m22);
      end
      matrices_checked++;
    end
  end

  function automatic logic [AW-1:0] random_angle();
    logic [AW-1:0] special[10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000,
                                   16'h3FFF, 16'hBFFF, 16'h0001, 16'hFFFF, 16'h2000};
    if ($urandom_range(0, 7) == 0) return special[$urandom_range(0, 9)];
    return AW'($urandom);
  endfunction

  initial begin
    int total;
    logic [AW-1:0] edges[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000,
                                16'hC000, 16'h0001, 16'hFFFF, 16'h3FFF};
    // Extremes and quadrant boundaries, minus pi on each angle in turn.
    for (int i = 0; i < 8; i++) begin
      pending_angles.push_back({edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]});
    end
    pending_angles.push_back({16'h8000, 16'h8000, 16'h8000});
    pending_angles.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
    pending_angles.push_back({16'h0000, 16'h0000, 16'h0000});
    pending_angles.push_back({16'h5555, 16'hAAAA, 16'h5555});
    pending_angles.push_back({16'hAAAA, 16'h5555, 16'hAAAA});
    // A bit pattern close to +-1 products, where saturation may bite.
    pending_angles.push_back({16'h0000, 16'h4000, 16'h0000});
    pending_angles.push_back({16'h8000, 16'hC000, 16'h8000});
    for (int i = 0; i < 1550; i++) begin
      pending_angles.push_back({random_angle(), random_angle(), random_angle()});
    end
    total = pending_angles.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_angles.size() > 0 || (in_valid === 1'b1)) @(posedge clk);
    while (expected_matrices.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d of %0d angle triples including extremes and minus pi; checked %0d",
             angles_sent, total, matrices_checked);
    $display("matrices with bursty input, random output stalls and one long hold-off.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
